// ===== sv/atc_pkg.sv =====
package atc_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int EXP_TABLE_BITS = 8;
  localparam int TBL_N          = 1 << EXP_TABLE_BITS;
  localparam int EXPO_W         = 6;   // integer part of the base-2 exponent

  localparam logic [30:0] L2E_Q30 = 31'd1549082005;  // log2(e), Q.30
  localparam logic [63:0] LN2_Q30 = 64'd744261118;   // ln(2), Q.30

  localparam int unsigned SCALE_RST = 4369;
  localparam int unsigned RATE_RST  = 181704;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 2'd2;

  typedef logic [31:0] pow2_tbl_t [0:TBL_N];

  // valid bit and exponent that ride along with the mantissa lookup
  typedef struct packed {
    logic              valid;
    logic [EXPO_W-1:0] expo;
  } atc_tag_t;

  // 2^(i/TBL_N) in Q.30 from a Taylor series of exp(i*ln2/TBL_N)
  function automatic pow2_tbl_t build_pow2_tbl();
    pow2_tbl_t   tbl;
    logic [63:0] z;
    logic [63:0] term;
    logic [63:0] sum;
    for (int i = 0; i <= TBL_N; i++) begin
      z    = (64'(i) * LN2_Q30 + 64'(TBL_N / 2)) >> EXP_TABLE_BITS;
      term = 64'd1 << 30;
      sum  = 64'd1 << 30;
      for (int k = 1; k <= 24; k++) begin
        term = ((term * z + (64'd1 << 29)) >> 30) / 64'(k);
        sum  = sum + term;
      end
      tbl[i] = sum[31:0];
    end
    tbl[0]     = 32'd1 << 30;
    tbl[TBL_N] = 32'd1 << 31;
    return tbl;
  endfunction

  localparam pow2_tbl_t POW2_TBL = build_pow2_tbl();

endpackage

// ===== sv/atc_pow2.sv =====
// 2^f for a fraction f: table lookup, then linear interpolation (truncated).
// Two register stages.
module atc_pow2 #(
  parameter int FRAC_BITS = atc_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  atc_pkg::atc_tag_t    tag_i,
  input  logic [FRAC_BITS-1:0] frac_i,
  output atc_pkg::atc_tag_t    tag_o,
  output logic [31:0]          mant_o
);

  localparam int TB    = atc_pkg::EXP_TABLE_BITS;
  localparam int REM_W = 32 - TB;

  logic [31:0]      f32;
  logic [TB-1:0]    idx;
  logic [TB:0]      lo_idx, hi_idx;

  atc_pkg::atc_tag_t tag_a_q, tag_b_q;
  logic [31:0]      lo_q, hi_q;
  logic [REM_W-1:0] rem_q;
  logic [31:0]      diff;
  logic [REM_W+31:0] interp;
  logic [31:0]      mant_d, mant_q;

  assign f32    = 32'(frac_i) << (32 - FRAC_BITS);
  assign idx    = f32[31 -: TB];
  assign lo_idx = {1'b0, idx};
  assign hi_idx = lo_idx + (TB+1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
      tag_b_q <= '0;
    end else begin
      tag_a_q <= tag_i;
      tag_b_q <= tag_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q   <= atc_pkg::POW2_TBL[lo_idx];
    hi_q   <= atc_pkg::POW2_TBL[hi_idx];
    rem_q  <= f32[REM_W-1:0];
    mant_q <= mant_d;
  end

  always_comb begin
    diff   = (hi_q > lo_q) ? hi_q - lo_q : '0;
    interp = (REM_W+32)'(diff) * (REM_W+32)'(rem_q);
    mant_d = lo_q + interp[REM_W +: 32];
  end

  assign tag_o  = tag_b_q;
  assign mant_o = mant_q;

endmodule

// ===== sv/audio_taper_curve.sv =====
// Channel   Dir  Handshake                 Payload
// command   in   start_i, busy_o           position_i
// result    out  done_o (one-cycle strobe) level_o, clipped_o
// config    in   cfg_valid_i, cfg_ready_o  cfg_index_i, cfg_data_i
//
// Fully pipelined: a new word every cycle, busy_o is never raised.
// From start_i to done_o a word passes one register per multiply,
// plus the table read and the output register.
// Reset clears the valid bits and loads the default curve registers.
// Results cannot be held off; config writes are taken at any time and
// apply to words in flight, so write only with the pipeline empty.
module audio_taper_curve #(
  parameter int FRAC_BITS = atc_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [FRAC_BITS:0]   position_i,
  output logic                 done_o,
  output logic [FRAC_BITS:0]   level_o,
  output logic                 clipped_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [atc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [FRAC_BITS+7:0] cfg_data_i
);

  localparam int F     = FRAC_BITS;
  localparam int POS_W = F + 1;
  localparam int SC_W  = F + 8;
  localparam int RT_W  = F + 5;
  localparam int T_W   = F + 6;
  localparam int Y_W   = F + 6;
  localparam int E_W   = atc_pkg::EXPO_W;
  localparam int M1_W  = RT_W + POS_W + 1;
  localparam int M2_W  = T_W + 32;
  localparam int D_W   = F + 32;
  localparam int HI_W  = SC_W + F + 2;
  localparam int LO_W  = SC_W + 30;
  localparam int P_W   = HI_W + 1;

  localparam logic [POS_W-1:0] ONE = POS_W'(1) << F;

  // ---------------- configuration registers
  logic            mirror_q;
  logic [SC_W-1:0] scale_q;
  logic [RT_W-1:0] rate_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mirror_q <= 1'b0;
      scale_q  <= SC_W'(atc_pkg::SCALE_RST);
      rate_q   <= RT_W'(atc_pkg::RATE_RST);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        atc_pkg::CFG_MIRROR: mirror_q <= cfg_data_i[0];
        atc_pkg::CFG_SCALE:  scale_q  <= cfg_data_i[SC_W-1:0];
        atc_pkg::CFG_RATE:   rate_q   <= cfg_data_i[RT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage 1: t = b*arg
  logic [POS_W-1:0] pos_sat, arg;
  logic [M1_W-1:0]  m1;
  logic [T_W-1:0]   t_q;
  logic             v1_q;

  always_comb begin
    pos_sat = (position_i > ONE) ? ONE : position_i;
    arg     = mirror_q ? ONE - pos_sat : pos_sat;
    m1      = M1_W'(rate_q) * M1_W'(arg) + (M1_W'(1) << (F - 1));
  end

  // ---------------- stage 2: y = t*log2(e)
  logic [M2_W-1:0] m2;
  logic [Y_W-1:0]  y_q;
  logic            v2_q;

  assign m2 = M2_W'(t_q) * M2_W'(atc_pkg::L2E_Q30) + (M2_W'(1) << 29);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q <= m1[F +: T_W];
    y_q <= m2[30 +: Y_W];
  end

  // ---------------- stages 3-4: mantissa 2^f
  atc_pkg::atc_tag_t tag_in, tag_out;
  logic [31:0]       mant;

  assign tag_in.valid = v2_q;
  assign tag_in.expo  = y_q[F +: E_W];

  atc_pow2 #(
    .FRAC_BITS (F)
  ) u_pow2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tag_i  (tag_in),
    .frac_i (y_q[F-1:0]),
    .tag_o  (tag_out),
    .mant_o (mant)
  );

  // ---------------- stage 5: d = m*2^n - 1, split products with a
  logic [D_W-1:0]  shm, dval;
  logic [HI_W-1:0] hi_d, hi_q;
  logic [LO_W-1:0] lo_d, lo_q;
  logic            big_d, big_q, v5_q;

  always_comb begin
    big_d = tag_out.expo >= E_W'(F + 2);
    shm   = D_W'(mant) << tag_out.expo;
    dval  = shm - (D_W'(1) << 30);
    hi_d  = HI_W'(scale_q) * HI_W'(dval[30 +: F + 2]);
    lo_d  = LO_W'(scale_q) * LO_W'(dval[29:0]);
  end

  // ---------------- stage 6: round, saturate
  logic [LO_W:0]  lo_rnd;
  logic [P_W-1:0] prod;
  logic           clip;
  logic [POS_W-1:0] level_d, level_q;
  logic           clip_q, v6_q;

  always_comb begin
    lo_rnd = (LO_W+1)'(lo_q) + ((LO_W+1)'(1) << 29);
    prod   = P_W'(hi_q) + P_W'(lo_rnd[LO_W:30]);
    // a of zero never clips, even with a huge exponent
    clip   = (scale_q != '0) && (big_q || prod > P_W'(ONE));
    if (mirror_q) begin
      level_d = clip ? '0 : ONE - prod[POS_W-1:0];
    end else begin
      level_d = clip ? ONE : prod[POS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v5_q <= tag_out.valid;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q    <= hi_d;
    lo_q    <= lo_d;
    big_q   <= big_d;
    level_q <= level_d;
    clip_q  <= clip;
  end

  assign done_o    = v6_q;
  assign level_o   = level_q;
  assign clipped_o = clip_q;

endmodule
